// ----- sv/erm_pkg.sv -----
// Package for the echo range median filter: field widths, register indexes,
// reset values, the conversion reciprocal and the controller command struct.
// It depends on nothing else.
package erm_pkg;

  localparam int unsigned DUR_W    = 16;
  localparam int unsigned DIST_W   = 15;
  localparam int unsigned RAW_W    = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned OUT_W    = RAW_W + 1 + DIST_W;

  localparam int unsigned WINDOW_SIZE_DEF = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd2;

  localparam logic [DIST_W-1:0] MIN_DIST_RST = 15'd32;
  localparam logic [DIST_W-1:0] MAX_DIST_RST = 15'd6400;
  localparam logic [DUR_W-1:0]  TIMEOUT_RST  = 16'd30000;

  localparam logic [RAW_W-1:0] NO_ECHO_RAW = 16'hFFF0;

  // Distance = floor(duration * 343 / 1250), taken as duration * K >> 27.
  // K is rounded up; the error stays below the smallest fraction step.
  localparam int unsigned RECIP_K_W   = 26;
  localparam int unsigned RECIP_SHIFT = 27;
  localparam logic [RECIP_K_W-1:0] RECIP_K = 26'd36829345;
  localparam int unsigned PROD_W = DUR_W + RECIP_K_W;

  typedef struct packed {
    logic capture;
    logic mul;
    logic check;
    logic del;
    logic ins;
    logic load;
  } cmd_t;

endpackage

// ----- sv/echo_range_median_filter.sv -----
// Echo range median filter, top level: converts an echo duration to a
// distance, checks it and reports the median of a sliding window.
// An accepted word passes through capture, multiply, range check, delete and
// insert before its result is presented, later if the result register is still
// held; a new word is accepted only after the six-state controller sequence ends in the result load.
// Reset clears the controller, count and write slot and loads the configuration registers with their reset values.
module echo_range_median_filter #(
  parameter int unsigned WINDOW_SIZE = erm_pkg::WINDOW_SIZE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [erm_pkg::DUR_W-1:0]     s_axis_tdata,  // echo_duration
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [erm_pkg::OUT_W-1:0]     m_axis_tdata,  // raw_distance, in_range, median_distance
  input  logic                          cfg_we_i,
  input  logic [erm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [erm_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import erm_pkg::*;

  cmd_t cmd;

  erm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  erm_datapath #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .dur_i       (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_data_o  (m_axis_tdata)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a word is in progress");

  a_in_range_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[RAW_W]) |-> !m_axis_tdata[RAW_W-1])
    else $error("in-range result with negative raw distance");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a word in progress");

endmodule

// ----- sv/erm_ctrl.sv -----
// Controller of the echo range median filter: sequences one word through
// capture, multiply, range check, delete, insert and result load.
// Depends on erm_pkg.
module erm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output erm_pkg::cmd_t cmd_o
);
  import erm_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_DEL  = 3'd3;
  localparam logic [2:0] ST_INS  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = ST_CHK;
      end
      ST_CHK: begin
        cmd_o.check = 1'b1;
        state_d = ST_DEL;
      end
      ST_DEL: begin
        cmd_o.del = 1'b1;
        state_d = ST_INS;
      end
      ST_INS: begin
        cmd_o.ins = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd_o.load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- sv/erm_datapath.sv -----
// Datapath of the echo range median filter: configuration registers,
// conversion, range check, ring memory and the sorted window cells.
// Depends on erm_pkg and is driven by erm_ctrl.
module erm_datapath #(
  parameter int unsigned WINDOW_SIZE = erm_pkg::WINDOW_SIZE_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  erm_pkg::cmd_t                  cmd_i,
  input  logic [erm_pkg::DUR_W-1:0]      dur_i,
  input  logic                           cfg_we_i,
  input  logic [erm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [erm_pkg::CFG_W-1:0]      cfg_wdata_i,
  output logic [erm_pkg::OUT_W-1:0]      out_data_o
);
  import erm_pkg::*;

  localparam int unsigned CNT_W  = $clog2(WINDOW_SIZE + 1);
  localparam int unsigned ADDR_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;

  logic [DIST_W-1:0] min_dist_q, max_dist_q;
  logic [DUR_W-1:0]  timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dist_q <= MIN_DIST_RST;
      max_dist_q <= MAX_DIST_RST;
      timeout_q  <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_DIST: min_dist_q <= cfg_wdata_i[DIST_W-1:0];
        CFG_MAX_DIST: max_dist_q <= cfg_wdata_i[DIST_W-1:0];
        CFG_TIMEOUT:  timeout_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [DUR_W-1:0]  dur_q;
  logic [PROD_W-1:0] prod_q;
  logic [DIST_W-1:0] dist_val;
  logic              echo, valid;
  logic [RAW_W-1:0]  raw_q;
  logic              valid_q;
  logic [DIST_W-1:0] push_q, old_q;
  logic [OUT_W-1:0]  out_q;

  assign dist_val = prod_q[RECIP_SHIFT +: DIST_W];
  assign echo     = (dur_q != '0) && (dur_q <= timeout_q);
  assign valid    = echo && (dist_val >= min_dist_q) && (dist_val <= max_dist_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) dur_q <= dur_i;
    if (cmd_i.mul) prod_q <= PROD_W'(dur_q) * PROD_W'(RECIP_K);
    if (cmd_i.check) begin
      raw_q   <= echo ? {1'b0, dist_val} : NO_ECHO_RAW;
      valid_q <= valid;
      push_q  <= valid ? dist_val : max_dist_q;
    end
  end

  logic [ADDR_W-1:0] wpos_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              full;
  logic [DIST_W-1:0] ring_mem [WINDOW_SIZE];

  assign full = (cnt_q == CNT_W'(WINDOW_SIZE));

  always_ff @(posedge clk_i) begin
    if (cmd_i.del) ring_mem[wpos_q] <= push_q;
    if (cmd_i.capture) old_q <= ring_mem[wpos_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (cmd_i.del && full) cnt_q <= cnt_q - CNT_W'(1);
      if (cmd_i.ins) begin
        cnt_q  <= cnt_q + CNT_W'(1);
        wpos_q <= (wpos_q == ADDR_W'(WINDOW_SIZE - 1)) ? '0 : wpos_q + ADDR_W'(1);
      end
    end
  end

  // Sorted copy of the window; cells at or beyond the count act as infinity.
  logic [DIST_W-1:0]      sorted_q [WINDOW_SIZE];
  logic [WINDOW_SIZE-1:0] filled, gt, ge;

  for (genvar k = 0; k < WINDOW_SIZE; k++) begin : g_cell
    logic [DIST_W-1:0] ins_val, del_val;

    assign filled[k] = (CNT_W'(k) < cnt_q);
    assign gt[k] = !filled[k] || (sorted_q[k] > push_q);
    assign ge[k] = filled[k] && (sorted_q[k] >= old_q);

    if (k == 0) begin : g_first
      assign ins_val = gt[k] ? push_q : sorted_q[k];
    end else begin : g_rest
      assign ins_val = gt[k] ? (gt[k-1] ? sorted_q[k-1] : push_q) : sorted_q[k];
    end

    if (k == WINDOW_SIZE - 1) begin : g_last
      assign del_val = sorted_q[k];
    end else begin : g_inner
      assign del_val = ge[k] ? sorted_q[k+1] : sorted_q[k];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.del && full) sorted_q[k] <= del_val;
      else if (cmd_i.ins) sorted_q[k] <= ins_val;
    end
  end

  logic [ADDR_W-1:0] mid;
  assign mid = ADDR_W'(cnt_q >> 1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) out_q <= {sorted_q[mid], valid_q, raw_q};
  end

  assign out_data_o = out_q;

endmodule

// ----- tb/sv/erm_reading_checker.sv -----
`timescale 1ns / 100ps
// Checker for the echo range median filter: watches the input, output and
// configuration ports, predicts each reading and compares it with the block.
// It depends on erm_pkg for field widths, register indexes and reset values.
module erm_reading_checker #(
  parameter int unsigned WINDOW_SIZE = erm_pkg::WINDOW_SIZE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [erm_pkg::DUR_W-1:0]     s_tdata_i,  // echo_duration
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic [erm_pkg::OUT_W-1:0]     m_tdata_i,  // raw_distance, in_range, median_distance
  input  logic                          cfg_we_i,
  input  logic [erm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [erm_pkg::CFG_W-1:0]     cfg_wdata_i,
  output int                            pending_o,
  output int                            mismatches_o
);
  import erm_pkg::*;

  typedef struct packed {
    logic              in_range;
    logic [DIST_W-1:0] median;
    logic [RAW_W-1:0]  raw;
  } reading_t;

  reading_t          expected_readings[$];
  logic [DIST_W-1:0] min_dist;
  logic [DIST_W-1:0] max_dist;
  logic [DUR_W-1:0]  echo_tmo;
  logic [DIST_W-1:0] window_q [WINDOW_SIZE];
  int unsigned       slot;
  int unsigned       filled;
  int                mismatch_count;

  function automatic reading_t predict_reading(input logic [DUR_W-1:0] dur);
    reading_t          r;
    logic [31:0]       dist_val;
    logic              echo;
    logic [DIST_W-1:0] sorted_q [WINDOW_SIZE];
    logic [DIST_W-1:0] key;
    int                i;
    int                j;
    echo = (dur != '0) && (dur <= echo_tmo);
    dist_val = echo ? (32'(dur) * 32'd343) / 32'd1250 : 32'd0;
    r.in_range = echo && (dist_val >= 32'(min_dist)) && (dist_val <= 32'(max_dist));
    r.raw = echo ? dist_val[RAW_W-1:0] : NO_ECHO_RAW;
    window_q[slot] = r.in_range ? dist_val[DIST_W-1:0] : max_dist;
    slot = (slot + 1 >= WINDOW_SIZE) ? 0 : slot + 1;
    if (filled < WINDOW_SIZE) filled++;
    for (i = 0; i < int'(filled); i++) sorted_q[i] = window_q[i];
    for (i = 1; i < int'(filled); i++) begin
      key = sorted_q[i];
      j = i;
      while (j > 0 && sorted_q[j-1] > key) begin
        sorted_q[j] = sorted_q[j-1];
        j--;
      end
      sorted_q[j] = key;
    end
    r.median = sorted_q[filled / 2];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t want;
    reading_t got;
    if (!rst_ni) begin
      min_dist = MIN_DIST_RST;
      max_dist = MAX_DIST_RST;
      echo_tmo = TIMEOUT_RST;
      slot = 0;
      filled = 0;
      mismatch_count = 0;
      expected_readings.delete();
      pending_o <= 0;
      mismatches_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_DIST: min_dist = cfg_wdata_i[DIST_W-1:0];
          CFG_MAX_DIST: max_dist = cfg_wdata_i[DIST_W-1:0];
          CFG_TIMEOUT:  echo_tmo = cfg_wdata_i;
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        got.raw = m_tdata_i[RAW_W-1:0];
        got.in_range = m_tdata_i[RAW_W];
        got.median = m_tdata_i[RAW_W+1 +: DIST_W];
        if (expected_readings.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result word with no reading expected: raw %0d in_range %0b median %0d",
                     $time, $signed(got.raw), got.in_range, got.median);
        end else begin
          want = expected_readings.pop_front();
          if (got.raw != want.raw || got.in_range != want.in_range
              || got.median != want.median) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: reading mismatch: raw %0d/%0d in_range %0b/%0b median %0d/%0d (expected/actual)",
                       $time, $signed(want.raw), $signed(got.raw), want.in_range,
                       got.in_range, want.median, got.median);
          end
        end
      end
      if (s_tvalid_i && s_tready_i) expected_readings.push_back(predict_reading(s_tdata_i));
      pending_o <= expected_readings.size();
      mismatches_o <= mismatch_count;
    end
  end

endmodule

// ----- tb/sv/tb_echo_range_median_filter.sv -----
`timescale 1ns / 100ps
// Testbench top for the echo range median filter: drives echo durations and
// register writes with random idling, and gives the verdict from the checker.
// It depends on erm_pkg, echo_range_median_filter and erm_reading_checker.
module tb_echo_range_median_filter;
  import erm_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned RANDOM_PHASES   = 10;
  localparam int unsigned PHASE_WORDS     = 193;
  localparam int unsigned SETTLE_CYCLES   = 12;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DUR_W-1:0]     s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 hold_off_req = 1'b0;
  int                   pending_readings;
  int                   mismatches;
  int                   lo_dist;
  int                   hi_dist;
  int                   tmo_us;

  echo_range_median_filter #(
    .WINDOW_SIZE(WINDOW_SIZE_DEF)
  ) u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata)
  );

  erm_reading_checker #(
    .WINDOW_SIZE(WINDOW_SIZE_DEF)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .pending_o   (pending_readings),
    .mismatches_o(mismatches)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_echo_range_median_filter NOT OK");
    $finish;
  end

  // The receiver changes its readiness pattern after runs of random length and,
  // once asked, refuses results for a long stretch so that the block backs up.
  initial begin
    int pct;
    int run_len;
    bit hold_done;
    hold_done = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      case ($urandom_range(0, 3))
        0: pct = 100;
        1: pct = 50;
        2: pct = 15;
        default: pct = 80;
      endcase
      run_len = $urandom_range(4, 48);
      repeat (run_len) begin
        m_axis_tready <= ($urandom_range(0, 99) < pct);
        @(posedge clk);
      end
    end
  end

  task automatic send_word(input logic [DUR_W-1:0] dur);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= dur;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_readings != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limits(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                            input logic [CFG_W-1:0] tmo);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_MIN_DIST;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_idx <= CFG_MAX_DIST;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_idx <= CFG_TIMEOUT;
    cfg_wdata <= tmo;
    @(posedge clk);
    cfg_idx <= CFG_UNUSED;
    cfg_wdata <= CFG_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    lo_dist = int'(lo[DIST_W-1:0]);
    hi_dist = int'(hi[DIST_W-1:0]);
    tmo_us = int'(tmo);
  endtask

  // Durations cluster on the range limits and the timeout, with no-echo
  // words mixed in; the rest spread over every duration with an echo.
  function automatic logic [DUR_W-1:0] pick_duration();
    int r;
    int target;
    int dur;
    r = $urandom_range(0, 99);
    if (r < 6) return '0;
    if (r < 14 && tmo_us < 65535) return DUR_W'($urandom_range(65535, tmo_us + 1));
    if (r < 34) begin
      target = $urandom_range(0, 1) ? lo_dist : hi_dist;
      dur = (target * 1250 + 342) / 343 - 2 + int'($urandom_range(0, 4));
    end else if (r < 40) begin
      dur = tmo_us + 1 - int'($urandom_range(0, 3));
    end else begin
      dur = int'($urandom_range(tmo_us, 1));
    end
    if (dur < 1) dur = 1;
    if (dur > 65535) dur = 65535;
    return DUR_W'(dur);
  endfunction

  task automatic stream_random(input int words);
    int left;
    int burst;
    int gap;
    left = words;
    while (left > 0) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 12);
      if (burst > left) burst = left;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      repeat (burst) send_word(pick_duration());
      left -= burst;
    end
  endtask

  initial begin
    logic [CFG_W-1:0] lo;
    logic [CFG_W-1:0] hi;
    logic [CFG_W-1:0] tmo;
    int p;
    lo_dist = int'(MIN_DIST_RST);
    hi_dist = int'(MAX_DIST_RST);
    tmo_us = int'(TIMEOUT_RST);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset limits: no echo, both range edges and the timeout edge.
    send_word(16'd0);
    send_word(16'd1);
    send_word(16'd116);
    send_word(16'd117);
    send_word(16'd23327);
    send_word(16'd23328);
    send_word(16'd30000);
    send_word(16'd30001);
    send_word(16'd65535);

    // Widest range and longest timeout.
    set_limits(16'd0, 16'd32767, 16'd65535);
    send_word(16'd65535);
    send_word(16'd1);
    send_word(16'd4);
    send_word(16'h5555);
    send_word(16'hAAAA);

    // Inverted range with the top bit set in the write data, shortest timeout.
    set_limits(16'hFFFF, 16'd0, 16'd1);
    send_word(16'd1);
    send_word(16'd2);
    send_word(16'd0);

    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin lo = MIN_DIST_RST; hi = MAX_DIST_RST; tmo = TIMEOUT_RST; end
        1: begin lo = 16'd0; hi = 16'h7FFF; tmo = 16'hFFFF; end
        2: begin lo = 16'd0; hi = 16'd0; tmo = 16'hFFFF; end
        3: begin lo = 16'h7FFF; hi = 16'h7FFF; tmo = 16'hFFFF; end
        4: begin
          hi = CFG_W'($urandom_range(0, 15000));
          lo = hi + CFG_W'($urandom_range(1, 3000));
          tmo = CFG_W'($urandom_range(1000, 65535));
        end
        default: begin
          lo = CFG_W'($urandom_range(0, 12000));
          hi = lo + CFG_W'($urandom_range(0, 8000));
          tmo = CFG_W'($urandom_range(1, 65535));
        end
      endcase
      lo[DIST_W] = $urandom_range(0, 1);
      hi[DIST_W] = $urandom_range(0, 1);
      set_limits(lo, hi, tmo);
      if (p == 1) hold_off_req <= 1'b1;
      stream_random(PHASE_WORDS);
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("tb_echo_range_median_filter OK");
    end else begin
      $display("tb_echo_range_median_filter NOT OK");
    end
    $finish;
  end

endmodule
